/* src/idll_pkg.sv */
package idll_pkg;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_PREPEND = 3'd1,
    OP_BEFORE  = 3'd2,
    OP_AFTER   = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_MEMBER  = 3'd5,
    OP_CLEAR   = 3'd6
  } opcode_e;

  // Separate write enables for the two link fields of one memory word.
  typedef struct packed {
    logic we_a;
    logic we_b;
  } field_we_t;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 8;

endpackage

/* src/indexed_doubly_linked_list_manager.sv */
// Manages many disjoint doubly linked lists over a pool of NODE_COUNT indices.
// The slave stream carries one operation per beat: append, prepend, insert
// before or after a reference node, remove, membership test or clear. Every
// accepted beat produces exactly one result beat on the master stream, with
// present and bad_list; only a membership test can set either of them.
// Head pointers and node links live in two synchronous memories with
// registered read data; each list update reads its links, then writes
// them back, at most one word of each memory per cycle.
// An append or remove runs through S_LOOK, S_W1 and S_W2 to S_DONE;
// prepend and inserts add S_W3; an ignored operation goes straight to
// S_DONE; a membership test steps through the list in S_LOOK and S_WALK
// and stops at the node, at the end of the list, or with bad_list set
// at its NODE_COUNT-th element. A clear sweeps both memories one entry
// per cycle. After reset the same sweep runs with s_axis_tready low. The
// result sits in an output register; while the receiver stalls, the
// next operation still runs and waits only to hand over its result.
module indexed_doubly_linked_list_manager import idll_pkg::*; #(
  parameter int unsigned NODE_COUNT = 256,
  localparam int unsigned IW = $clog2(NODE_COUNT),
  localparam int unsigned PW = IW + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // opcode[2:0], parent[10:3], child[18:11], other_node[26:19], zeros above.
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // present[0], bad_list[1], zeros above.
  output logic [OutDataW-1:0] m_axis_tdata
);

  field_we_t     head_we, node_we;
  logic [IW-1:0] head_raddr, head_waddr, node_raddr, node_waddr;
  logic [PW-1:0] head_rd_first, head_rd_last, head_wd_first, head_wd_last;
  logic [PW-1:0] node_rd_prev, node_rd_next, node_wd_prev, node_wd_next;
  logic          present, bad_list;

  idll_ctrl #(
    .NODE_COUNT(NODE_COUNT)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_valid_i      (s_axis_tvalid),
    .s_ready_o      (s_axis_tready),
    .opcode_i       (s_axis_tdata[2:0]),
    .parent_i       (s_axis_tdata[10:3]),
    .child_i        (s_axis_tdata[18:11]),
    .other_node_i   (s_axis_tdata[26:19]),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .present_o      (present),
    .bad_list_o     (bad_list),
    .head_raddr_o   (head_raddr),
    .head_rd_first_i(head_rd_first),
    .head_rd_last_i (head_rd_last),
    .head_we_o      (head_we),
    .head_waddr_o   (head_waddr),
    .head_wd_first_o(head_wd_first),
    .head_wd_last_o (head_wd_last),
    .node_raddr_o   (node_raddr),
    .node_rd_prev_i (node_rd_prev),
    .node_rd_next_i (node_rd_next),
    .node_we_o      (node_we),
    .node_waddr_o   (node_waddr),
    .node_wd_prev_o (node_wd_prev),
    .node_wd_next_o (node_wd_next)
  );

  idll_link_ram #(
    .DEPTH (NODE_COUNT),
    .DATA_W(PW)
  ) u_head_ram (
    .clk_i    (clk_i),
    .we_i     (head_we),
    .waddr_i  (head_waddr),
    .wdata_a_i(head_wd_first),
    .wdata_b_i(head_wd_last),
    .raddr_i  (head_raddr),
    .rdata_a_o(head_rd_first),
    .rdata_b_o(head_rd_last)
  );

  idll_link_ram #(
    .DEPTH (NODE_COUNT),
    .DATA_W(PW)
  ) u_node_ram (
    .clk_i    (clk_i),
    .we_i     (node_we),
    .waddr_i  (node_waddr),
    .wdata_a_i(node_wd_prev),
    .wdata_b_i(node_wd_next),
    .raddr_i  (node_raddr),
    .rdata_a_o(node_rd_prev),
    .rdata_b_o(node_rd_next)
  );

  assign m_axis_tdata = {(OutDataW - 2)'(0), bad_list, present};

endmodule

/* src/idll_link_ram.sv */
module idll_link_ram import idll_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned DATA_W = 9,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  field_we_t         we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_a_i,
  input  logic [DATA_W-1:0] wdata_b_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [2*DATA_W-1:0] mem_q [DEPTH];
  logic [2*DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i.we_a) begin
      mem_q[waddr_i][2*DATA_W-1:DATA_W] <= wdata_a_i;
    end
    if (we_i.we_b) begin
      mem_q[waddr_i][DATA_W-1:0] <= wdata_b_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_a_o = rdata_q[2*DATA_W-1:DATA_W];
  assign rdata_b_o = rdata_q[DATA_W-1:0];

endmodule

/* src/idll_ctrl.sv */
module idll_ctrl import idll_pkg::*; #(
  parameter int unsigned NODE_COUNT = 256,
  localparam int unsigned IW = $clog2(NODE_COUNT),
  localparam int unsigned PW = IW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  logic [2:0]    opcode_i,
  input  logic [7:0]    parent_i,
  input  logic [7:0]    child_i,
  input  logic [7:0]    other_node_i,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic          present_o,
  output logic          bad_list_o,
  output logic [IW-1:0] head_raddr_o,
  input  logic [PW-1:0] head_rd_first_i,
  input  logic [PW-1:0] head_rd_last_i,
  output field_we_t     head_we_o,
  output logic [IW-1:0] head_waddr_o,
  output logic [PW-1:0] head_wd_first_o,
  output logic [PW-1:0] head_wd_last_o,
  output logic [IW-1:0] node_raddr_o,
  input  logic [PW-1:0] node_rd_prev_i,
  input  logic [PW-1:0] node_rd_next_i,
  output field_we_t     node_we_o,
  output logic [IW-1:0] node_waddr_o,
  output logic [PW-1:0] node_wd_prev_o,
  output logic [PW-1:0] node_wd_next_o
);

  localparam int unsigned CW = (IW > 8) ? IW : 8;
  localparam logic [PW-1:0] EmptyPtr = {PW{1'b1}};
  localparam logic [IW-1:0] LastIdx = IW'(NODE_COUNT - 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_LOOK  = 8'b0000_0100,
    S_WALK  = 8'b0000_1000,
    S_W1    = 8'b0001_0000,
    S_W2    = 8'b0010_0000,
    S_W3    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e        state_q, state_d;
  opcode_e       op_q, op_d;
  logic [IW-1:0] p_q, p_d, c_q, c_d;
  logic [7:0]    o_q, o_d;
  logic [PW-1:0] la_q, la_d, lb_q, lb_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] swp_q, swp_d;
  logic          clr_rsp_q, clr_rsp_d;
  logic          found_q, found_d, bad_q, bad_d;
  logic          out_valid_q, out_valid_d;
  logic          present_q, present_d, bad_list_q, bad_list_d;
  logic          out_load;
  logic [PW-1:0] cur;
  logic [PW-1:0] c_ptr, o_ptr;

  function automatic logic in_pool(input logic [7:0] x);
    return 32'(x) < 32'(NODE_COUNT);
  endfunction

  assign c_ptr = {1'b0, c_q};
  assign o_ptr = {1'b0, IW'(o_q)};
  assign cur = (state_q == S_LOOK) ? head_rd_first_i : node_rd_next_i;

  assign s_ready_o = (state_q == S_IDLE);
  assign head_raddr_o = IW'(parent_i);
  assign node_raddr_o = (state_q == S_IDLE) ? IW'(child_i) : cur[IW-1:0];
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_ready_i);

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    p_d = p_q;
    c_d = c_q;
    o_d = o_q;
    la_d = la_q;
    lb_d = lb_q;
    cnt_d = cnt_q;
    swp_d = swp_q;
    clr_rsp_d = clr_rsp_q;
    found_d = found_q;
    bad_d = bad_q;
    head_we_o = '0;
    head_waddr_o = p_q;
    head_wd_first_o = c_ptr;
    head_wd_last_o = c_ptr;
    node_we_o = '0;
    node_waddr_o = c_q;
    node_wd_prev_o = EmptyPtr;
    node_wd_next_o = EmptyPtr;

    case (state_q)
      S_CLEAR: begin
        head_we_o = '{we_a: 1'b1, we_b: 1'b1};
        node_we_o = '{we_a: 1'b1, we_b: 1'b1};
        head_waddr_o = swp_q;
        node_waddr_o = swp_q;
        head_wd_first_o = EmptyPtr;
        head_wd_last_o = EmptyPtr;
        swp_d = swp_q + IW'(1);
        if (swp_q == LastIdx) begin
          state_d = clr_rsp_q ? S_DONE : S_IDLE;
          clr_rsp_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (s_valid_i) begin
          op_d = opcode_e'(opcode_i);
          p_d = IW'(parent_i);
          c_d = IW'(child_i);
          o_d = other_node_i;
          cnt_d = '0;
          found_d = 1'b0;
          bad_d = 1'b0;
          case (opcode_e'(opcode_i))
            OP_APPEND, OP_PREPEND, OP_REMOVE: begin
              state_d = (in_pool(parent_i) && in_pool(child_i)) ? S_LOOK : S_DONE;
            end
            OP_BEFORE, OP_AFTER: begin
              state_d = (in_pool(parent_i) && in_pool(child_i) && in_pool(other_node_i))
                        ? S_LOOK : S_DONE;
            end
            OP_MEMBER: begin
              state_d = in_pool(parent_i) ? S_LOOK : S_DONE;
            end
            OP_CLEAR: begin
              state_d = S_CLEAR;
              clr_rsp_d = 1'b1;
              swp_d = '0;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_LOOK, S_WALK: begin
        if (op_q == OP_MEMBER) begin
          if (cur[PW-1]) begin
            state_d = S_DONE;
          end else if (cnt_q == LastIdx) begin
            bad_d = 1'b1;
            state_d = S_DONE;
          end else if (CW'(cur[IW-1:0]) == CW'(o_q)) begin
            found_d = 1'b1;
            state_d = S_DONE;
          end else begin
            cnt_d = cnt_q + IW'(1);
            state_d = S_WALK;
          end
        end else begin
          if (op_q inside {OP_APPEND, OP_PREPEND}) begin
            la_d = head_rd_first_i;
            lb_d = head_rd_last_i;
          end else begin
            la_d = node_rd_prev_i;
            lb_d = node_rd_next_i;
          end
          state_d = S_W1;
        end
      end
      S_W1: begin
        state_d = S_W2;
        case (op_q)
          OP_APPEND: begin
            node_we_o.we_b = !lb_q[PW-1];
            node_waddr_o = lb_q[IW-1:0];
            node_wd_next_o = c_ptr;
          end
          OP_PREPEND: begin
            node_we_o.we_b = 1'b1;
            node_wd_next_o = la_q;
          end
          OP_BEFORE: begin
            node_we_o = '{we_a: 1'b1, we_b: 1'b1};
            node_waddr_o = IW'(o_q);
            node_wd_prev_o = la_q;
            node_wd_next_o = c_ptr;
          end
          OP_AFTER: begin
            node_we_o = '{we_a: 1'b1, we_b: 1'b1};
            node_waddr_o = IW'(o_q);
            node_wd_prev_o = c_ptr;
            node_wd_next_o = lb_q;
          end
          OP_REMOVE: begin
            head_we_o.we_a = la_q[PW-1];
            head_wd_first_o = lb_q;
            node_we_o.we_b = !la_q[PW-1];
            node_waddr_o = la_q[IW-1:0];
            node_wd_next_o = lb_q;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_W2: begin
        state_d = S_W3;
        case (op_q)
          OP_APPEND: begin
            node_we_o = '{we_a: 1'b1, we_b: 1'b1};
            node_wd_prev_o = lb_q;
            node_wd_next_o = EmptyPtr;
            head_we_o = '{we_a: lb_q[PW-1], we_b: 1'b1};
            state_d = S_DONE;
          end
          OP_PREPEND: begin
            node_we_o.we_a = !la_q[PW-1];
            node_waddr_o = la_q[IW-1:0];
            node_wd_prev_o = c_ptr;
          end
          OP_BEFORE: begin
            node_we_o.we_a = 1'b1;
            node_wd_prev_o = o_ptr;
          end
          OP_AFTER: begin
            node_we_o.we_b = 1'b1;
            node_wd_next_o = o_ptr;
          end
          OP_REMOVE: begin
            head_we_o.we_b = lb_q[PW-1];
            head_wd_last_o = la_q;
            node_we_o.we_a = !lb_q[PW-1];
            node_waddr_o = lb_q[IW-1:0];
            node_wd_prev_o = la_q;
            state_d = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_W3: begin
        state_d = S_DONE;
        case (op_q)
          OP_PREPEND: begin
            node_we_o.we_a = 1'b1;
            node_wd_prev_o = EmptyPtr;
            head_we_o = '{we_a: 1'b1, we_b: la_q[PW-1]};
          end
          OP_BEFORE: begin
            head_we_o.we_a = la_q[PW-1];
            head_wd_first_o = o_ptr;
            node_we_o.we_b = !la_q[PW-1];
            node_waddr_o = la_q[IW-1:0];
            node_wd_next_o = o_ptr;
          end
          OP_AFTER: begin
            head_we_o.we_b = lb_q[PW-1];
            head_wd_last_o = o_ptr;
            node_we_o.we_a = !lb_q[PW-1];
            node_waddr_o = lb_q[IW-1:0];
            node_wd_prev_o = o_ptr;
          end
          default: begin
          end
        endcase
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    present_d = present_q;
    bad_list_d = bad_list_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      present_d = found_q;
      bad_list_d = bad_q;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      swp_q <= '0;
      clr_rsp_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      swp_q <= swp_d;
      clr_rsp_q <= clr_rsp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    p_q <= p_d;
    c_q <= c_d;
    o_q <= o_d;
    la_q <= la_d;
    lb_q <= lb_d;
    cnt_q <= cnt_d;
    found_q <= found_d;
    bad_q <= bad_d;
    present_q <= present_d;
    bad_list_q <= bad_list_d;
  end

  assign m_valid_o = out_valid_q;
  assign present_o = present_q;
  assign bad_list_o = bad_list_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (head_we_o == '0) && (node_we_o == '0))
    else $error("link memory written during a membership walk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> head_we_o.we_a && head_we_o.we_b && node_we_o.we_a
                             && node_we_o.we_b)
    else $error("clearing pass skipped an entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(present_q && bad_list_q))
    else $error("result reports a found node on a bad list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q == S_IDLE) && out_valid_q)
    else $error("result load did not return to idle");
`endif

endmodule
